@@ rtl/spatial_hash_bucket_occupancy_query_assert.svh @@
// ----------------------------------------------------------------------------
// Spatial hash bucket occupancy query: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPATIAL_HASH_BUCKET_OCCUPANCY_QUERY_ASSERT_SVH
`define SPATIAL_HASH_BUCKET_OCCUPANCY_QUERY_ASSERT_SVH

// same-cycle implication
`define SHBOQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHBOQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/shboq_pkg.sv @@
// ----------------------------------------------------------------------------
// Spatial hash bucket occupancy query: package
// Widths, hash primes, register map and the per-axis walk descriptor.
// ----------------------------------------------------------------------------
package shboq_pkg;

  localparam int HASH_BITS = 12;
  localparam int ROW_BITS  = 6;
  localparam int COL_BITS  = 6;
  localparam int COLS      = 64;
  localparam int COORD_W   = 32;
  localparam int INV_W     = 25;
  localparam int MASK_W    = 12;
  localparam int SPAN_W    = 13;
  localparam int CELL_W    = 25;
  localparam int CNT_W     = 13;
  localparam int PROD_W    = 58;
  localparam int DIFF_W    = 26;
  localparam int REG_W     = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int NUM_CORNERS = 6;

  localparam logic [CNT_W-1:0] HASH_SPACE = 13'd4096;

  localparam logic [2:0][31:0] PRIMES = {32'd83492791, 32'd19349663, 32'd73856093};

  localparam logic [INV_W-1:0]  INV_RESET  = 25'd65536;
  localparam logic [MASK_W-1:0] MASK_RESET = 12'd4095;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 13'd4096;

  localparam logic [1:0] REG_INV  = 2'd0;
  localparam logic [1:0] REG_MASK = 2'd1;
  localparam logic [1:0] REG_SPAN = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    logic [HASH_BITS-1:0] start;
    logic [HASH_BITS-1:0] step;
  } axis_info_t;

endpackage

@@ rtl/shboq_ram.sv @@
// ----------------------------------------------------------------------------
// Spatial hash bucket occupancy query: RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module shboq_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/shboq_axis.sv @@
// ----------------------------------------------------------------------------
// Spatial hash bucket occupancy query: axis setup
// Scales the six box corners to cell coordinates on one shared multiplier,
// then clamps each axis span and forms its first hash term and term step.
// ----------------------------------------------------------------------------
module shboq_axis (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic signed [shboq_pkg::COORD_W-1:0]     box_min_x,
  input  logic signed [shboq_pkg::COORD_W-1:0]     box_min_y,
  input  logic signed [shboq_pkg::COORD_W-1:0]     box_min_z,
  input  logic signed [shboq_pkg::COORD_W-1:0]     box_max_x,
  input  logic signed [shboq_pkg::COORD_W-1:0]     box_max_y,
  input  logic signed [shboq_pkg::COORD_W-1:0]     box_max_z,
  input  logic [shboq_pkg::INV_W-1:0]              inv_size,
  input  logic [shboq_pkg::SPAN_W-1:0]             span,
  output logic                                     done,
  output shboq_pkg::axis_info_t [2:0]              info
);

  logic signed [shboq_pkg::COORD_W-1:0] coord    [shboq_pkg::NUM_CORNERS];
  logic signed [shboq_pkg::CELL_W-1:0]  cell_pos [shboq_pkg::NUM_CORNERS];
  logic                                 busy;
  logic [2:0]                           step;
  logic signed [shboq_pkg::COORD_W-1:0] coord_sel;
  logic signed [shboq_pkg::INV_W:0]     inv_s;
  logic signed [shboq_pkg::PROD_W-1:0]  prod;
  shboq_pkg::axis_info_t [2:0]          info_next;

  assign coord_sel = (step < 3'(shboq_pkg::NUM_CORNERS)) ? coord[step] : '0;
  assign inv_s     = {1'b0, inv_size};
  assign prod      = coord_sel * inv_s;

  always_comb begin
    logic [shboq_pkg::DIFF_W-1:0] diff;
    logic [shboq_pkg::CNT_W-1:0]  dcl;
    logic [2*shboq_pkg::HASH_BITS-1:0] sp;
    for (int a = 0; a < 3; a++) begin
      diff = {cell_pos[a+3][shboq_pkg::CELL_W-1], cell_pos[a+3]}
           - {cell_pos[a][shboq_pkg::CELL_W-1], cell_pos[a]};
      dcl  = (diff[shboq_pkg::CELL_W-1:0] > shboq_pkg::CELL_W'(span))
           ? span : diff[shboq_pkg::CNT_W-1:0];
      if (diff[shboq_pkg::DIFF_W-1]) begin
        info_next[a].count = '0;
      end else if (dcl >= shboq_pkg::HASH_SPACE - 13'd1) begin
        info_next[a].count = shboq_pkg::HASH_SPACE;
      end else begin
        info_next[a].count = dcl + 13'd1;
      end
      sp = cell_pos[a][shboq_pkg::HASH_BITS-1:0]
         * shboq_pkg::PRIMES[a][shboq_pkg::HASH_BITS-1:0];
      info_next[a].start = sp[shboq_pkg::HASH_BITS-1:0];
      info_next[a].step  = shboq_pkg::PRIMES[a][shboq_pkg::HASH_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        coord[0] <= box_min_x;
        coord[1] <= box_min_y;
        coord[2] <= box_min_z;
        coord[3] <= box_max_x;
        coord[4] <= box_max_y;
        coord[5] <= box_max_z;
        busy     <= 1'b1;
        step     <= '0;
      end else if (busy) begin
        if (step < 3'(shboq_pkg::NUM_CORNERS)) begin
          cell_pos[step] <= prod[shboq_pkg::CELL_W+31:32];
          step           <= step + 3'd1;
        end else begin
          info <= info_next;
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/spatial_hash_bucket_occupancy_query.sv @@
// ----------------------------------------------------------------------------
// Spatial hash bucket occupancy query
// Bucket flags live in a 64 x 64-bit RAM. A write word reads its flag row and
// writes it back. A query word first scales the corners and sets up the axes,
// then makes two shift-and-OR passes over a scratch RAM, each over all 64 rows
// per hash term of one of the two shorter axes and each followed by a gap
// state, then looks up each term of the longest axis, ending at the first hit.
// When an axis covers 4096 or more cells the passes are skipped and the flag
// RAM is scanned row by row instead. The 64-row passes set the query time. Row
// valid bits stand in for clearing, so there is no clearing pass after reset.
// A finished result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module spatial_hash_bucket_occupancy_query (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_min_x,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_min_y,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_min_z,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_max_x,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_max_y,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_max_z,
  input  logic [shboq_pkg::HASH_BITS-1:0]      bucket_index,
  input  logic                                 bucket_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 touches_occupied,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [shboq_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [shboq_pkg::REG_W-1:0]          pwdata,
  output logic [shboq_pkg::REG_W-1:0]          prdata,
  output logic                                 pready
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_WR_RD = 10'b0000000010,
    S_WR_WB = 10'b0000000100,
    S_AXIS  = 10'b0000001000,
    S_ORDER = 10'b0000010000,
    S_PASS  = 10'b0000100000,
    S_GAP   = 10'b0001000000,
    S_LOOK  = 10'b0010000000,
    S_SCAN  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  localparam int RB = shboq_pkg::ROW_BITS;
  localparam int CB = shboq_pkg::COL_BITS;
  localparam int HB = shboq_pkg::HASH_BITS;
  localparam int NC = shboq_pkg::COLS;
  localparam int NR = 2 ** RB;

  state_t                         state;
  logic [shboq_pkg::INV_W-1:0]    inv_size;
  logic [shboq_pkg::MASK_W-1:0]   bmask;
  logic [shboq_pkg::SPAN_W-1:0]   span;
  logic [HB-1:0]                  wr_index;
  logic                           wr_value;
  logic [NR-1:0]                  flag_valid;
  logic [1:0][NR-1:0]             sv;
  shboq_pkg::axis_info_t [2:0]    slot;
  shboq_pkg::axis_info_t [2:0]    slot_next;
  shboq_pkg::axis_info_t [2:0]    ai;
  shboq_pkg::axis_info_t          act;
  logic                           pidx;
  logic [shboq_pkg::CNT_W-1:0]    k;
  logic [RB-1:0]                  r;
  logic [RB:0]                    scan_row;
  logic [HB-1:0]                  term;
  logic [HB-1:0]                  term_m;
  logic                           s1_valid;
  logic [RB-1:0]                  s1_dst;
  logic [CB-1:0]                  s1_tlo;
  logic                           s1_fwd;
  logic                           s1_dst_ok;
  logic                           s1_src_ok;
  logic [NC-1:0]                  last_wdata;
  logic                           chk_valid;
  logic                           chk_ok;
  logic [CB-1:0]                  chk_tlo;
  logic                           hit;
  logic                           in_accept;
  logic                           cfg_we;
  logic                           ax_done;
  logic                           any_empty;
  logic                           any_full;
  logic [RB-1:0]                  p_dst;
  logic                           p_last;
  logic [NC-1:0]                  colm;
  logic                           scan_rowok;
  logic                           flag_we;
  logic [RB-1:0]                  flag_raddr;
  logic [NC-1:0]                  flag_q;
  logic [NC-1:0]                  flag_row_upd;
  logic [RB:0]                    sa_raddr;
  logic [RB:0]                    sb_raddr;
  logic [NC-1:0]                  sa_q;
  logic [NC-1:0]                  sb_q;
  logic [NC-1:0]                  src_row;
  logic [NC-1:0]                  perm;
  logic [NC-1:0]                  dst_old;
  logic [NC-1:0]                  pass_wdata;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    case (paddr[3:2])
      shboq_pkg::REG_INV:  prdata = shboq_pkg::REG_W'(inv_size);
      shboq_pkg::REG_MASK: prdata = shboq_pkg::REG_W'(bmask);
      shboq_pkg::REG_SPAN: prdata = shboq_pkg::REG_W'(span);
      default:             prdata = '0;
    endcase
  end

  shboq_axis u_axis (
    .clk       (clk),
    .rst       (rst),
    .start     (in_accept && kind),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_min_z (box_min_z),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y),
    .box_max_z (box_max_z),
    .inv_size  (inv_size),
    .span      (span),
    .done      (ax_done),
    .info      (ai)
  );

  // longest axis goes last, to the lookup
  always_comb begin
    if (ai[0].count >= ai[1].count && ai[0].count >= ai[2].count) begin
      slot_next = {ai[0], ai[2], ai[1]};
    end else if (ai[1].count >= ai[2].count) begin
      slot_next = {ai[1], ai[2], ai[0]};
    end else begin
      slot_next = {ai[2], ai[1], ai[0]};
    end
    any_empty = (ai[0].count == '0) || (ai[1].count == '0) || (ai[2].count == '0);
    any_full  = (ai[0].count == shboq_pkg::HASH_SPACE)
             || (ai[1].count == shboq_pkg::HASH_SPACE)
             || (ai[2].count == shboq_pkg::HASH_SPACE);
  end

  assign act        = (state == S_LOOK) ? slot[2] : (pidx ? slot[1] : slot[0]);
  assign term_m     = term & bmask;
  assign p_dst      = r ^ term_m[HB-1:CB];
  assign p_last     = (r == RB'(NR - 1)) && (k == act.count - 13'd1);
  assign scan_rowok = ((scan_row[RB-1:0] & ~bmask[HB-1:CB]) == '0);

  always_comb begin
    for (int j = 0; j < NC; j++) begin
      colm[j] = ((CB'(j) & ~bmask[CB-1:0]) == '0);
    end
  end

  // flag RAM
  always_comb begin
    case (state)
      S_WR_RD: flag_raddr = wr_index[HB-1:CB];
      S_SCAN:  flag_raddr = scan_row[RB-1:0];
      default: flag_raddr = r;
    endcase
  end

  always_comb begin
    flag_row_upd = flag_valid[wr_index[HB-1:CB]] ? flag_q : '0;
    flag_row_upd[wr_index[CB-1:0]] = wr_value;
  end

  assign flag_we = (state == S_WR_WB);

  shboq_ram #(.ADDR_W(RB), .DATA_W(NC)) u_flags (
    .clk   (clk),
    .we    (flag_we),
    .waddr (wr_index[HB-1:CB]),
    .wdata (flag_row_upd),
    .raddr (flag_raddr),
    .rdata (flag_q)
  );

  // scratch RAM, two copies for two read addresses
  assign sa_raddr = (state == S_LOOK) ? {1'b1, term_m[HB-1:CB]} : {1'b0, r};
  assign sb_raddr = {pidx, p_dst};

  always_comb begin
    src_row = pidx ? sa_q : flag_q;
    for (int j = 0; j < NC; j++) begin
      perm[j] = src_row[CB'(j) ^ s1_tlo];
    end
    dst_old    = s1_fwd ? last_wdata : (s1_dst_ok ? sb_q : '0);
    pass_wdata = dst_old | (s1_src_ok ? perm : '0);
  end

  shboq_ram #(.ADDR_W(RB + 1), .DATA_W(NC)) u_scratch_a (
    .clk   (clk),
    .we    (s1_valid),
    .waddr ({pidx, s1_dst}),
    .wdata (pass_wdata),
    .raddr (sa_raddr),
    .rdata (sa_q)
  );

  shboq_ram #(.ADDR_W(RB + 1), .DATA_W(NC)) u_scratch_b (
    .clk   (clk),
    .we    (s1_valid),
    .waddr ({pidx, s1_dst}),
    .wdata (pass_wdata),
    .raddr (sb_raddr),
    .rdata (sb_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      inv_size   <= shboq_pkg::INV_RESET;
      bmask      <= shboq_pkg::MASK_RESET;
      span       <= shboq_pkg::SPAN_RESET;
      out_valid  <= 1'b0;
      flag_valid <= '0;
      sv         <= '0;
      s1_valid   <= 1'b0;
      chk_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (paddr[3:2])
          shboq_pkg::REG_INV:  inv_size <= pwdata[shboq_pkg::INV_W-1:0];
          shboq_pkg::REG_MASK: bmask    <= pwdata[shboq_pkg::MASK_W-1:0];
          shboq_pkg::REG_SPAN: span     <= pwdata[shboq_pkg::SPAN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      s1_valid  <= 1'b0;
      chk_valid <= 1'b0;
      if (s1_valid) begin
        sv[pidx][s1_dst] <= 1'b1;
        last_wdata       <= pass_wdata;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            wr_index <= bucket_index;
            wr_value <= bucket_value;
            state    <= kind ? S_AXIS : S_WR_RD;
          end
        end
        S_WR_RD: begin
          state <= S_WR_WB;
        end
        S_WR_WB: begin
          flag_valid[wr_index[HB-1:CB]] <= 1'b1;
          state <= S_IDLE;
        end
        S_AXIS: begin
          if (ax_done) begin
            state <= S_ORDER;
          end
        end
        S_ORDER: begin
          slot     <= slot_next;
          sv       <= '0;
          pidx     <= 1'b0;
          k        <= '0;
          r        <= '0;
          term     <= slot_next[0].start;
          scan_row <= '0;
          if (any_empty) begin
            hit   <= 1'b0;
            state <= S_DONE;
          end else if (any_full) begin
            state <= S_SCAN;
          end else begin
            state <= S_PASS;
          end
        end
        S_PASS: begin
          s1_valid  <= 1'b1;
          s1_dst    <= p_dst;
          s1_tlo    <= term_m[CB-1:0];
          s1_fwd    <= s1_valid && (s1_dst == p_dst);
          s1_dst_ok <= sv[pidx][p_dst];
          s1_src_ok <= pidx ? sv[0][r] : flag_valid[r];
          r         <= r + RB'(1);
          if (r == RB'(NR - 1)) begin
            k    <= k + 13'd1;
            term <= term + act.step;
          end
          if (p_last) begin
            state <= S_GAP;
          end
        end
        S_GAP: begin
          k <= '0;
          r <= '0;
          if (!pidx) begin
            pidx  <= 1'b1;
            term  <= slot[1].start;
            state <= S_PASS;
          end else begin
            term  <= slot[2].start;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (k != act.count) begin
            chk_valid <= 1'b1;
            chk_tlo   <= term_m[CB-1:0];
            chk_ok    <= sv[1][term_m[HB-1:CB]];
            k         <= k + 13'd1;
            term      <= term + act.step;
          end
          if (chk_valid && chk_ok && sa_q[chk_tlo]) begin
            hit   <= 1'b1;
            state <= S_DONE;
          end else if (k == act.count && !chk_valid) begin
            hit   <= 1'b0;
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (!scan_row[RB]) begin
            chk_valid <= 1'b1;
            chk_ok    <= flag_valid[scan_row[RB-1:0]] && scan_rowok;
            scan_row  <= scan_row + (RB+1)'(1);
          end
          if (chk_valid && chk_ok && (|(flag_q & colm))) begin
            hit   <= 1'b1;
            state <= S_DONE;
          end else if (scan_row[RB] && !chk_valid) begin
            hit   <= 1'b0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            touches_occupied <= hit;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "spatial_hash_bucket_occupancy_query_assert.svh"

  `SHBOQ_ASSERT_NOW(a_scratch_write_in_pass, s1_valid, (state == S_PASS) || (state == S_GAP), "scratch write outside a pass")
  `SHBOQ_ASSERT_NOW(a_forward_follows_write, s1_valid && s1_fwd, $past(s1_valid), "forward without a pending write")
  `SHBOQ_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state == S_DONE), "result word not from done")
  `SHBOQ_ASSERT_NOW(a_lookup_bound, state == S_LOOK, k <= slot[2].count, "lookup ran past its term count")

endmodule

@@ dv/spatial_hash_bucket_occupancy_query_check.sv @@
// ----------------------------------------------------------------------------
// Spatial hash bucket occupancy query: checker
// Watches the input, output and register channels, keeps its own copy of
// the bucket flags and registers, predicts touches_occupied for every
// accepted query word and compares it with each accepted result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spatial_hash_bucket_occupancy_query_check (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 kind,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_min_x,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_min_y,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_min_z,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_max_x,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_max_y,
  input  logic signed [shboq_pkg::COORD_W-1:0] box_max_z,
  input  logic [shboq_pkg::HASH_BITS-1:0]      bucket_index,
  input  logic                                 bucket_value,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic                                 touches_occupied,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [shboq_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [shboq_pkg::REG_W-1:0]          pwdata,
  input  logic                                 pready,
  output int                                   failures,
  output int                                   outstanding
);
  import shboq_pkg::*;

  bit                occupied [0:4095];
  logic [INV_W-1:0]  inv_size;
  logic [MASK_W-1:0] mask;
  logic [SPAN_W-1:0] span_lim;
  bit                touch_pending [$];
  bit                want;
  int                errs = 0;

  function automatic logic signed [63:0] cell_of(input logic signed [31:0] coord);
    logic signed [63:0] c64;
    logic signed [63:0] i64;
    c64 = coord;
    i64 = $signed({39'd0, inv_size});
    return (c64 * i64) >>> 32;
  endfunction

  // set of masked hash terms along one axis
  function automatic logic [4095:0] axis_set(input logic signed [63:0] lo,
                                             input logic signed [63:0] hi,
                                             input logic [31:0] prime);
    logic signed [63:0] diff;
    logic [31:0]        c;
    logic [31:0]        h;
    logic [4095:0]      s;
    int                 n;
    s = '0;
    diff = hi - lo;
    if (diff > $signed({51'd0, span_lim})) diff = $signed({51'd0, span_lim});
    if (diff >= 0) begin
      n = (diff >= 4095) ? 4096 : int'(diff) + 1;
      c = lo[31:0];
      for (int k = 0; k < n; k++) begin
        h = c * prime;
        s[h[11:0] & mask] = 1'b1;
        c = c + 32'd1;
      end
    end
    return s;
  endfunction

  function automatic bit box_touches(input logic signed [31:0] mn_x, mn_y, mn_z,
                                     input logic signed [31:0] mx_x, mx_y, mx_z);
    logic [4095:0] sx, sy, sz, sxy;
    logic [11:0]   lx [0:4095];
    logic [11:0]   ly [0:4095];
    logic [11:0]   lz [0:4095];
    logic [11:0]   lxy [0:4095];
    int            nx, ny, nz, nxy, full;
    sx = axis_set(cell_of(mn_x), cell_of(mx_x), PRIMES[0]);
    sy = axis_set(cell_of(mn_y), cell_of(mx_y), PRIMES[1]);
    sz = axis_set(cell_of(mn_z), cell_of(mx_z), PRIMES[2]);
    if (sx == '0 || sy == '0 || sz == '0) return 1'b0;
    // an axis that fills the masked subspace makes every masked bucket reachable
    full = 1 << $countones(mask);
    if ($countones(sx) == full || $countones(sy) == full || $countones(sz) == full) begin
      for (int f = 0; f < 4096; f++)
        if (occupied[f] && ((f[11:0] & ~mask) == 12'd0)) return 1'b1;
      return 1'b0;
    end
    nx = 0;
    ny = 0;
    nz = 0;
    for (int v = 0; v < 4096; v++) begin
      if (sx[v]) begin
        lx[nx] = v[11:0];
        nx++;
      end
      if (sy[v]) begin
        ly[ny] = v[11:0];
        ny++;
      end
      if (sz[v]) begin
        lz[nz] = v[11:0];
        nz++;
      end
    end
    sxy = '0;
    for (int i = 0; i < nx; i++)
      for (int j = 0; j < ny; j++)
        sxy[lx[i] ^ ly[j]] = 1'b1;
    nxy = 0;
    for (int v = 0; v < 4096; v++) begin
      if (sxy[v]) begin
        lxy[nxy] = v[11:0];
        nxy++;
      end
    end
    for (int i = 0; i < nz; i++)
      for (int j = 0; j < nxy; j++)
        if (occupied[lz[i] ^ lxy[j]]) return 1'b1;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4096; i++) occupied[i] = 1'b0;
      inv_size = INV_RESET;
      mask = MASK_RESET;
      span_lim = SPAN_RESET;
      touch_pending.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_INV:  inv_size = pwdata[INV_W-1:0];
          REG_MASK: mask = pwdata[MASK_W-1:0];
          REG_SPAN: span_lim = pwdata[SPAN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (touch_pending.size() == 0) begin
          $error("touches_occupied: expected none, actual %0d", touches_occupied);
          errs++;
        end else begin
          want = touch_pending.pop_front();
          if (touches_occupied !== want) begin
            $error("touches_occupied: expected %0d, actual %0d", want, touches_occupied);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (!kind) occupied[bucket_index] = bucket_value;
        else touch_pending.push_back(box_touches(box_min_x, box_min_y, box_min_z,
                                                 box_max_x, box_max_y, box_max_z));
      end
    end
    failures <= errs;
    outstanding <= touch_pending.size();
  end

endmodule

@@ dv/spatial_hash_bucket_occupancy_query_test.sv @@
// ----------------------------------------------------------------------------
// Spatial hash bucket occupancy query: testbench top
// Drives flag writes and box queries through several register settings,
// with random gaps on both channels, a long output hold-off and a full
// drain, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spatial_hash_bucket_occupancy_query_test;
  import shboq_pkg::*;

  localparam int LIMIT       = 3000000;
  localparam int HOLD_CYCLES = 600;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  kind = 1'b0;
  logic signed [31:0]    box_min_x = '0;
  logic signed [31:0]    box_min_y = '0;
  logic signed [31:0]    box_min_z = '0;
  logic signed [31:0]    box_max_x = '0;
  logic signed [31:0]    box_max_y = '0;
  logic signed [31:0]    box_max_z = '0;
  logic [HASH_BITS-1:0]  bucket_index = '0;
  logic                  bucket_value = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  touches_occupied;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [REG_W-1:0]      pwdata = '0;
  logic [REG_W-1:0]      prdata;
  logic                  pready;

  int failures;
  int outstanding;
  int cycles = 0;
  bit calm = 1'b0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;

  logic [INV_W-1:0]  cur_inv = INV_RESET;
  logic [MASK_W-1:0] cur_mask = MASK_RESET;

  spatial_hash_bucket_occupancy_query dut (.*);

  spatial_hash_bucket_occupancy_query_check occupancy_check (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("spatial_hash_bucket_occupancy_query_test: FAIL");
      $finish;
    end
  end

  // output side: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 12);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] clamp_coord(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] corner_pick();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic send_word(input bit k,
                           input logic [31:0] mn_x, mn_y, mn_z, mx_x, mx_y, mx_z,
                           input logic [11:0] idx, input bit val);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    box_min_x <= mn_x;
    box_min_y <= mn_y;
    box_min_z <= mn_z;
    box_max_x <= mx_x;
    box_max_y <= mx_y;
    box_max_z <= mx_z;
    bucket_index <= idx;
    bucket_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] r, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold input, wait out every query, then let a trailing flag write settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] inv, input logic [31:0] msk,
                            input logic [31:0] span);
    drain();
    write_reg(REG_INV, inv);
    write_reg(REG_MASK, msk);
    write_reg(REG_SPAN, span);
    cur_inv = inv[INV_W-1:0];
    cur_mask = msk[MASK_W-1:0];
  endtask

  task automatic send_small_box(input int reach, input int flip);
    logic [31:0]        lo [3];
    logic [31:0]        hi [3];
    logic [31:0]        t;
    logic [63:0]        unit;
    logic signed [63:0] base;
    logic signed [63:0] width;
    unit = (cur_inv == 0) ? 64'h1_0000_0000 : (64'h1_0000_0000 / cur_inv);
    for (int a = 0; a < 3; a++) begin
      base = $signed(rand64() % (8 * unit + 1)) - $signed(4 * unit);
      width = $signed(rand64() % (reach * unit + 1));
      lo[a] = clamp_coord(base);
      hi[a] = clamp_coord(base + width);
      if (a == flip && lo[a] != hi[a]) begin
        t = lo[a];
        lo[a] = hi[a];
        hi[a] = t;
      end
    end
    send_word(1'b1, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
              $urandom_range(0, 4095), $urandom_range(0, 1));
  endtask

  // set or clear the bucket of a cell near the origin
  task automatic send_cell_write();
    logic [31:0] ux, uy, uz, h;
    ux = $urandom_range(0, 8) - 4;
    uy = $urandom_range(0, 8) - 4;
    uz = $urandom_range(0, 8) - 4;
    h = (ux * PRIMES[0]) ^ (uy * PRIMES[1]) ^ (uz * PRIMES[2]);
    send_word(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              h[11:0] & cur_mask, $urandom_range(0, 9) < 7);
  endtask

  task automatic run_phase(input int count, input int reach, input bit noisy);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 28) send_cell_write();
      else if (r < 38)
        send_word(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(0, 4095), $urandom_range(0, 1));
      else if (r < 80) send_small_box(reach, -1);
      else if (r < 86) send_small_box(reach, $urandom_range(0, 2));
      else if (r < 92)
        send_word(1'b1, corner_pick(), corner_pick(), corner_pick(),
                  corner_pick(), corner_pick(), corner_pick(),
                  $urandom_range(0, 4095), $urandom_range(0, 1));
      else if (noisy)
        send_word($urandom_range(0, 1), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom,
                  $urandom_range(0, 4095), $urandom_range(0, 1));
      else send_small_box(reach, -1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: unit cells, full mask, widest span
    send_word(1'b1, 0, 0, 0, 0, 0, 0, 12'd0, 1'b0);
    send_word(1'b0, '1, '1, '1, '1, '1, '1, 12'd0, 1'b1);
    send_word(1'b1, 0, 0, 0, 0, 0, 0, 12'd4095, 1'b1);
    send_word(1'b1, 32'h0001_0000, 0, 0, 0, 0, 0, 12'd0, 1'b0);
    send_word(1'b1, 0, 0, 32'h0002_0000, 0, 0, 32'hFFFF_0000, 12'd0, 1'b0);
    send_word(1'b0, 0, 0, 0, 0, 0, 0, 12'd4095, 1'b1);
    send_word(1'b0, 0, 0, 0, 0, 0, 0, 12'd0, 1'b0);
    send_word(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd0, 1'b0);
    send_word(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd0, 1'b0);
    send_word(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 12'd0, 1'b0);
    send_word(1'b1, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 12'd0, 1'b0);
    send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 12'd0, 1'b0);
    send_word(1'b0, 0, 0, 0, 0, 0, 0, 12'd4095, 1'b0);
    send_word(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd0, 1'b0);

    // zero inverse cell size: every corner lands on cell zero
    set_config(0, 4095, 4096);
    send_word(1'b0, 0, 0, 0, 0, 0, 0, 12'd0, 1'b1);
    send_word(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              12'd0, 1'b0);
    send_word(1'b0, 0, 0, 0, 0, 0, 0, 12'd0, 1'b0);
    send_word(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd0, 1'b0);

    // fine cells, no span beyond the minimum
    set_config(16777216, 4095, 0);
    send_small_box(2, -1);
    send_small_box(2, -1);
    send_word(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd0, 1'b0);

    set_config(65536, 4095, 4096);
    run_phase(150, 2, 1'b0);

    // hold the output long while words keep coming
    set_config(16777216, 63, 3);
    hold_ticket <= hold_ticket + 1;
    run_phase(100, 3, 1'b1);

    set_config(1, 0, 0);
    run_phase(40, 2, 1'b1);

    set_config($urandom_range(1, 16777216), $urandom_range(0, 4095), $urandom_range(0, 8));
    calm <= 1'b1;
    run_phase(100, 3, 1'b1);
    calm <= 1'b0;

    set_config($urandom_range(30000, 90000), 4095, 4095);
    run_phase(150, 3, 1'b0);

    set_config(65536, 2047, 2);
    run_phase(40, 2, 1'b1);
    drain();
    run_phase(40, 2, 1'b1);

    drain();
    if (failures == 0) $display("spatial_hash_bucket_occupancy_query_test: PASS");
    else $display("spatial_hash_bucket_occupancy_query_test: FAIL");
    $finish;
  end

endmodule
